// ===== hw/rtl/sdiv_pkg.sv =====
package sdiv_pkg;

  localparam int unsigned WIDTH   = 32;
  localparam int unsigned REM_W   = 31;
  localparam int unsigned STEPS   = WIDTH;
  // prep register, one register per division step, output register
  localparam int unsigned LATENCY = STEPS + 2;

  typedef struct packed {
    logic             valid;
    logic             neg;    // signs differ, negate quotient at the end
    logic             zero;   // divisor was zero
    logic [WIDTH-1:0] rem;    // partial remainder
    logic [WIDTH-1:0] nq;     // dividend bits shift out at the top, quotient bits in at the bottom
    logic [WIDTH-1:0] dmag;   // divisor magnitude
  } stage_t;

endpackage

// ===== hw/rtl/sdiv_prep.sv =====
module sdiv_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic signed [sdiv_pkg::WIDTH-1:0] dividend,
  input  logic signed [sdiv_pkg::WIDTH-1:0] divisor,
  output sdiv_pkg::stage_t              stg_out
);

  logic [sdiv_pkg::WIDTH-1:0] nmag;
  logic [sdiv_pkg::WIDTH-1:0] dmag;

  // the most negative value keeps its bit pattern, read as unsigned 2^31
  assign nmag = dividend[sdiv_pkg::WIDTH-1] ? (~dividend + 1'b1) : dividend;
  assign dmag = divisor[sdiv_pkg::WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_out.valid <= 1'b0;
    end else begin
      stg_out.valid <= take;
    end
    stg_out.neg  <= dividend[sdiv_pkg::WIDTH-1] ^ divisor[sdiv_pkg::WIDTH-1];
    stg_out.zero <= (divisor == '0);
    stg_out.rem  <= '0;
    stg_out.nq   <= nmag;
    stg_out.dmag <= dmag;
  end

endmodule

// ===== hw/rtl/sdiv_step.sv =====
module sdiv_step (
  input  logic             clk,
  input  logic             rst,
  input  sdiv_pkg::stage_t stg_in,
  output sdiv_pkg::stage_t stg_out
);

  logic [sdiv_pkg::WIDTH-1:0] rem_sh;
  logic                       fits;

  // remainder stays below the divisor magnitude, so its top bit is free to shift out
  assign rem_sh = {stg_in.rem[sdiv_pkg::WIDTH-2:0], stg_in.nq[sdiv_pkg::WIDTH-1]};
  assign fits   = (rem_sh >= stg_in.dmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_out.valid <= 1'b0;
    end else begin
      stg_out.valid <= stg_in.valid;
    end
    stg_out.neg  <= stg_in.neg;
    stg_out.zero <= stg_in.zero;
    stg_out.rem  <= fits ? (rem_sh - stg_in.dmag) : rem_sh;
    stg_out.nq   <= {stg_in.nq[sdiv_pkg::WIDTH-2:0], fits};
    stg_out.dmag <= stg_in.dmag;
  end

endmodule

// ===== hw/rtl/sdiv_fix.sv =====
module sdiv_fix (
  input  logic                                clk,
  input  logic                                rst,
  input  sdiv_pkg::stage_t                    stg_in,
  output logic                                strobe,
  output logic signed [sdiv_pkg::WIDTH-1:0]   quotient,
  output logic        [sdiv_pkg::REM_W-1:0]   remainder
);

  logic [sdiv_pkg::WIDTH-1:0] q_fixed;

  assign q_fixed = stg_in.neg ? (~stg_in.nq + 1'b1) : stg_in.nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= stg_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    quotient  <= stg_in.zero ? '0 : q_fixed;
    remainder <= stg_in.zero ? '0 : stg_in.rem[sdiv_pkg::REM_W-1:0];
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    stg_in.valid && !stg_in.zero |-> stg_in.rem < stg_in.dmag)
    else $error("remainder not below divisor magnitude");

endmodule

// ===== hw/rtl/signed_restoring_divider.sv =====
// Signed 32-bit divider, fully pipelined: one division can start on every clock, busy
// never rises, and each item's quotient and remainder appear with strobe after passing
// through the operand register loaded at the edge that takes start, one register per
// quotient bit over 32 restoring steps, and one sign-fix output register.
// Results cannot be held off, so
// they must be captured in the cycle strobe is high. The quotient truncates toward zero and
// wraps (most negative / -1 gives the most negative value); the remainder is the unsigned
// magnitude; a zero divisor gives zero for both.
module signed_restoring_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sdiv_pkg::WIDTH-1:0]   dividend,
  input  logic signed [sdiv_pkg::WIDTH-1:0]   divisor,
  output logic                                strobe,
  output logic signed [sdiv_pkg::WIDTH-1:0]   quotient,
  output logic        [sdiv_pkg::REM_W-1:0]   remainder
);

  sdiv_pkg::stage_t stg [0:sdiv_pkg::STEPS];
  logic             take;

  assign busy = 1'b0;
  assign take = start && !busy;

  sdiv_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .dividend (dividend),
    .divisor  (divisor),
    .stg_out  (stg[0])
  );

  for (genvar i = 0; i < sdiv_pkg::STEPS; i++) begin : g_step
    sdiv_step u_step (
      .clk     (clk),
      .rst     (rst),
      .stg_in  (stg[i]),
      .stg_out (stg[i+1])
    );
  end

  sdiv_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .stg_in    (stg[sdiv_pkg::STEPS]),
    .strobe    (strobe),
    .quotient  (quotient),
    .remainder (remainder)
  );

  a_item_out: assert property (@(posedge clk) disable iff (rst)
    take |-> ##(sdiv_pkg::LATENCY) strobe)
    else $error("item did not come out on time");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(take, sdiv_pkg::LATENCY))
    else $error("result without an item");

  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(take && (divisor == '0), sdiv_pkg::LATENCY)
      |-> (quotient == '0) && (remainder == '0))
    else $error("zero divisor gave nonzero result");

endmodule
